// ===== src/hrdp_pkg.sv =====
// Shared types and constants of the HID report descriptor parser.
package hrdp_pkg;

  // Item prefixes handled by the assembler and the executor
  localparam logic [7:0] PfxLong     = 8'hFE;
  localparam logic [7:0] PfxPage     = 8'h05;
  localparam logic [7:0] PfxMin1     = 8'h15;
  localparam logic [7:0] PfxMin2     = 8'h16;
  localparam logic [7:0] PfxMin4     = 8'h17;
  localparam logic [7:0] PfxMax1     = 8'h25;
  localparam logic [7:0] PfxMax2     = 8'h26;
  localparam logic [7:0] PfxMax4     = 8'h27;
  localparam logic [7:0] PfxSize     = 8'h75;
  localparam logic [7:0] PfxId       = 8'h85;
  localparam logic [7:0] PfxCount    = 8'h95;
  localparam logic [7:0] PfxUsage    = 8'h09;
  localparam logic [7:0] PfxUmin1    = 8'h19;
  localparam logic [7:0] PfxUmin2    = 8'h1A;
  localparam logic [7:0] PfxUmin4    = 8'h1B;
  localparam logic [7:0] PfxUmax1    = 8'h29;
  localparam logic [7:0] PfxUmax2    = 8'h2A;
  localparam logic [7:0] PfxUmax4    = 8'h2B;
  localparam logic [7:0] PfxInput    = 8'h81;
  localparam logic [7:0] PfxPush     = 8'hA4;
  localparam logic [7:0] PfxPop      = 8'hB4;

  localparam logic [6:0] FieldLimitReset = 7'd32;

  // Long item skipping phases
  typedef enum logic [1:0] {
    SK_NONE,
    SK_LEN,
    SK_TAG,
    SK_DATA
  } skip_e;

  // Executor states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EMIT,
    BK_FIN
  } back_e;

  // Completed item handed from front to back
  typedef struct packed {
    logic        start;
    logic        exec;
    logic [7:0]  prefix;
    logic [31:0] data;
    logic [2:0]  width;
  } item_t;

  // One field record
  typedef struct packed {
    logic [5:0]  field_index;
    logic [7:0]  use_pg;
    logic [15:0] use_code;
    logic [7:0]  rpt_tag;
    logic [15:0] bit_pos;
    logic [7:0]  bit_len;
    logic [31:0] lo_limit;
    logic [31:0] hi_limit;
    logic        rel_flag;
    logic        last_of_run;
  } record_t;

  // Sign extension of item data by its byte count
  function automatic logic [31:0] signed_data(input logic [31:0] d, input logic [2:0] w);
    logic [31:0] r;
    r = d;
    if (w == 3'd1) begin
      r = {{24{d[7]}}, d[7:0]};
    end else if (w == 3'd2) begin
      r = {{16{d[15]}}, d[15:0]};
    end
    return r;
  endfunction

endpackage

// ===== src/hrdp_front.sv =====
// Byte assembler: splits the descriptor stream into items and skips long items.
module hrdp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          desc_byte_i,
  input  logic                start_req_i,
  output logic                item_valid_o,
  output hrdp_pkg::item_t     item_o
);

  hrdp_pkg::skip_e skip_q, skip_d;
  logic [7:0]  pend_q, pend_d;
  logic [7:0]  pre_q, pre_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  wid_q, wid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= hrdp_pkg::SK_NONE;
      pend_q <= '0;
      pre_q  <= '0;
      acc_q  <= '0;
      wid_q  <= '0;
    end else begin
      skip_q <= skip_d;
      pend_q <= pend_d;
      pre_q  <= pre_d;
      acc_q  <= acc_d;
      wid_q  <= wid_d;
    end
  end

  // Next state of the assembler for one accepted byte
  always_comb begin
    logic [1:0] pos;
    logic       done;
    skip_d = skip_q;
    pend_d = pend_q;
    pre_d  = pre_q;
    acc_d  = acc_q;
    wid_d  = wid_q;
    done   = 1'b0;
    pos    = '0;
    if (accept_i) begin
      if (start_req_i) begin
        skip_d = hrdp_pkg::SK_NONE;
        pend_d = '0;
        pre_d  = '0;
        acc_d  = '0;
        wid_d  = '0;
      end
      unique case (skip_d)
        hrdp_pkg::SK_LEN: begin
          pend_d = desc_byte_i;
          skip_d = hrdp_pkg::SK_TAG;
        end
        hrdp_pkg::SK_TAG: begin
          skip_d = (pend_d != 8'd0) ? hrdp_pkg::SK_DATA : hrdp_pkg::SK_NONE;
        end
        hrdp_pkg::SK_DATA: begin
          pend_d = pend_d - 8'd1;
          if (pend_d == 8'd0) skip_d = hrdp_pkg::SK_NONE;
        end
        default: begin
          if (pend_d != 8'd0) begin
            pos    = wid_d[1:0] - pend_d[1:0];
            acc_d  = acc_d | ({24'd0, desc_byte_i} << {pos, 3'b000});
            pend_d = pend_d - 8'd1;
            done   = (pend_d == 8'd0);
          end else if (desc_byte_i == hrdp_pkg::PfxLong) begin
            skip_d = hrdp_pkg::SK_LEN;
          end else begin
            pre_d  = desc_byte_i;
            wid_d  = (desc_byte_i[1:0] == 2'd3) ? 3'd4 : {1'b0, desc_byte_i[1:0]};
            pend_d = {5'd0, wid_d};
            acc_d  = '0;
            done   = (wid_d == 3'd0);
          end
        end
      endcase
    end
    item_valid_o  = accept_i && (start_req_i || done);
    item_o.start  = start_req_i;
    item_o.exec   = done;
    item_o.prefix = pre_d;
    item_o.data   = acc_d;
    item_o.width  = wid_d;
  end

endmodule

// ===== src/hrdp_queue.sv =====
// Two-entry item queue between the assembler and the executor.
module hrdp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  hrdp_pkg::item_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            valid_o,
  output hrdp_pkg::item_t rdata_o
);

  hrdp_pkg::item_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rp_q];

endmodule

// ===== src/hrdp_back.sv =====
// Item executor: global/local state, push/pop stack and field record emission.
module hrdp_back #(
  parameter int STACK_DEPTH = 4,
  parameter int USAGE_SLOTS = 8,
  parameter int FIELD_CAP   = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  hrdp_pkg::item_t   q_item_i,
  output logic              q_pop_o,
  input  logic [6:0]        field_limit_i,
  output logic              rec_valid_o,
  output hrdp_pkg::record_t rec_o,
  input  logic              rec_pop_i
);

  localparam int SLW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int ULW = $clog2(USAGE_SLOTS + 1);
  localparam int UIW = (USAGE_SLOTS > 1) ? $clog2(USAGE_SLOTS) : 1;

  hrdp_pkg::back_e st_q, st_d;
  logic           clr_done_q, clr_done_d;
  logic [7:0]     page_q, page_d, size_q, size_d, count_q, count_d, id_q, id_d;
  logic [31:0]    min_q, min_d, max_q, max_d;
  logic [15:0]    offs_q, offs_d;
  logic [SLW-1:0] lvl_q, lvl_d;
  logic [ULW-1:0] utot_q, utot_d, urun_q, urun_d;
  logic [UIW-1:0] uidx_q, uidx_d;
  logic [31:0]    rlow_q, rlow_d, rhigh_q, rhigh_d, bound_q, bound_d;
  logic           rval_q, rval_d, list_q, list_d, rel_q, rel_d;
  logic [6:0]     fout_q, fout_d, limit_q, limit_d, j_q, j_d;
  logic [7:0]     extra_q, extra_d;
  logic           outv_q, outv_d;
  hrdp_pkg::record_t rec_q, rec_d;

  logic [63:0]    lim_mem_q [STACK_DEPTH];
  logic [23:0]    siz_mem_q [STACK_DEPTH];
  logic [7:0]     ulist_q   [USAGE_SLOTS];
  logic           stk_we, ul_we;
  logic [SLW-1:0] lvl_m1;

  assign lvl_m1 = lvl_q - SLW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= hrdp_pkg::BK_IDLE;
      clr_done_q <= 1'b0;
      page_q <= '0; size_q <= '0; count_q <= '0; id_q <= '0;
      min_q <= '0; max_q <= '0; offs_q <= '0; lvl_q <= '0;
      utot_q <= '0; urun_q <= '0; uidx_q <= '0;
      rlow_q <= '0; rhigh_q <= '0; bound_q <= '0;
      rval_q <= 1'b0; list_q <= 1'b0; rel_q <= 1'b0;
      fout_q <= '0; limit_q <= '0; j_q <= '0; extra_q <= '0;
      outv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      clr_done_q <= clr_done_d;
      page_q <= page_d; size_q <= size_d; count_q <= count_d; id_q <= id_d;
      min_q <= min_d; max_q <= max_d; offs_q <= offs_d; lvl_q <= lvl_d;
      utot_q <= utot_d; urun_q <= urun_d; uidx_q <= uidx_d;
      rlow_q <= rlow_d; rhigh_q <= rhigh_d; bound_q <= bound_d;
      rval_q <= rval_d; list_q <= list_d; rel_q <= rel_d;
      fout_q <= fout_d; limit_q <= limit_d; j_q <= j_d; extra_q <= extra_d;
      outv_q <= outv_d;
    end
  end

  // Stack, usage list and output record storage
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      lim_mem_q[lvl_q[SIW-1:0]] <= {max_q, min_q};
      siz_mem_q[lvl_q[SIW-1:0]] <= {page_q, size_q, count_q};
    end
    if (ul_we) ulist_q[utot_q[UIW-1:0]] <= q_item_i.data[7:0];
    rec_q <= rec_d;
  end

  // Executor next state
  always_comb begin
    logic [7:0]  cnt;
    logic [31:0] sdat, range;
    logic [6:0]  lim;
    logic        slot_free, more;
    st_d = st_q; clr_done_d = clr_done_q;
    page_d = page_q; size_d = size_q; count_d = count_q; id_d = id_q;
    min_d = min_q; max_d = max_q; offs_d = offs_q; lvl_d = lvl_q;
    utot_d = utot_q; urun_d = urun_q; uidx_d = uidx_q;
    rlow_d = rlow_q; rhigh_d = rhigh_q; bound_d = bound_q;
    rval_d = rval_q; list_d = list_q; rel_d = rel_q;
    fout_d = fout_q; limit_d = limit_q; j_d = j_q; extra_d = extra_q;
    rec_d = rec_q;
    q_pop_o = 1'b0; stk_we = 1'b0; ul_we = 1'b0;
    slot_free = !outv_q || rec_pop_i;
    outv_d = outv_q && !rec_pop_i;
    cnt = (count_q == 8'd0) ? 8'd1 : count_q;
    sdat = hrdp_pkg::signed_data(q_item_i.data, q_item_i.width);
    range = rhigh_q - rlow_q + 32'd1;
    lim = (field_limit_i < 7'(FIELD_CAP)) ? field_limit_i : 7'(FIELD_CAP);
    more = 1'b0;
    unique case (st_q)
      hrdp_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.start && !clr_done_q) begin
            // start of a new descriptor: clear parse state
            page_d = '0; size_d = '0; count_d = '0; id_d = '0;
            min_d = '0; max_d = '0; offs_d = '0; lvl_d = '0; utot_d = '0;
            rlow_d = '0; rhigh_d = '0; rval_d = 1'b0; fout_d = '0;
            clr_done_d = q_item_i.exec;
            q_pop_o = !q_item_i.exec;
          end else begin
            clr_done_d = 1'b0;
            q_pop_o = 1'b1;
            if (q_item_i.exec) begin
              unique case (q_item_i.prefix)
                hrdp_pkg::PfxPage: page_d = q_item_i.data[7:0];
                hrdp_pkg::PfxMin1, hrdp_pkg::PfxMin2, hrdp_pkg::PfxMin4: min_d = sdat;
                hrdp_pkg::PfxMax1, hrdp_pkg::PfxMax2, hrdp_pkg::PfxMax4: max_d = sdat;
                hrdp_pkg::PfxSize: size_d = q_item_i.data[7:0];
                hrdp_pkg::PfxId: begin
                  id_d = q_item_i.data[7:0];
                  offs_d = '0;
                end
                hrdp_pkg::PfxCount: count_d = q_item_i.data[7:0];
                hrdp_pkg::PfxUsage: begin
                  if (utot_q < ULW'(USAGE_SLOTS)) begin
                    ul_we = 1'b1;
                    utot_d = utot_q + ULW'(1);
                  end
                end
                hrdp_pkg::PfxUmin1, hrdp_pkg::PfxUmin2, hrdp_pkg::PfxUmin4: begin
                  rlow_d = q_item_i.data;
                  rval_d = 1'b1;
                end
                hrdp_pkg::PfxUmax1, hrdp_pkg::PfxUmax2, hrdp_pkg::PfxUmax4: begin
                  rhigh_d = q_item_i.data;
                  rval_d = 1'b1;
                end
                hrdp_pkg::PfxPush: begin
                  if (lvl_q < SLW'(STACK_DEPTH)) begin
                    stk_we = 1'b1;
                    lvl_d = lvl_q + SLW'(1);
                  end
                end
                hrdp_pkg::PfxPop: begin
                  if (lvl_q != '0) begin
                    lvl_d = lvl_m1;
                    {max_d, min_d} = lim_mem_q[lvl_m1[SIW-1:0]];
                    {page_d, size_d, count_d} = siz_mem_q[lvl_m1[SIW-1:0]];
                  end
                end
                hrdp_pkg::PfxInput: begin
                  // Input item: choose list, range or offset-only handling
                  limit_d = lim;
                  rel_d = q_item_i.data[2];
                  j_d = '0;
                  uidx_d = '0;
                  urun_d = utot_q;
                  extra_d = '0;
                  utot_d = '0;
                  rval_d = 1'b0;
                  if (q_item_i.data[0] || (utot_q == '0 && !rval_q)) begin
                    offs_d = offs_q + 16'(size_q) * 16'(cnt);
                  end else begin
                    list_d = (utot_q != '0);
                    bound_d = list_d ? {24'd0, cnt} : range;
                    if (!list_d && ({24'd0, cnt} > range)) extra_d = cnt - range[7:0];
                    if (bound_d != 32'd0 && fout_q < lim) begin
                      st_d = hrdp_pkg::BK_EMIT;
                    end else if (extra_d != 8'd0) begin
                      st_d = hrdp_pkg::BK_FIN;
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
      hrdp_pkg::BK_EMIT: begin
        if (slot_free) begin
          more = ({25'd0, j_q} + 32'd1 < bound_q) && (fout_q + 7'd1 < limit_q);
          rec_d.field_index = fout_q[5:0];
          rec_d.use_pg      = page_q;
          rec_d.use_code    = list_q ? {8'd0, ulist_q[uidx_q]}
                                     : rlow_q[15:0] + {9'd0, j_q};
          rec_d.rpt_tag     = id_q;
          rec_d.bit_pos     = offs_q;
          rec_d.bit_len     = size_q;
          rec_d.lo_limit    = min_q;
          rec_d.hi_limit    = max_q;
          rec_d.rel_flag    = rel_q;
          rec_d.last_of_run = !more;
          outv_d = 1'b1;
          fout_d = fout_q + 7'd1;
          offs_d = offs_q + {8'd0, size_q};
          j_d = j_q + 7'd1;
          uidx_d = (ULW'(uidx_q) + ULW'(1) == urun_q) ? '0 : uidx_q + UIW'(1);
          if (!more) st_d = (extra_q != 8'd0) ? hrdp_pkg::BK_FIN : hrdp_pkg::BK_IDLE;
        end
      end
      hrdp_pkg::BK_FIN: begin
        // bits of the count beyond the usage range
        offs_d = offs_q + 16'(size_q) * 16'(extra_q);
        st_d = hrdp_pkg::BK_IDLE;
      end
      default: st_d = hrdp_pkg::BK_IDLE;
    endcase
  end

  assign rec_valid_o = outv_q;
  assign rec_o = rec_q;

`ifndef SYNTHESIS
  a_fields_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fout_q <= 7'(FIELD_CAP)) else $error("field count above cap");
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= SLW'(STACK_DEPTH)) else $error("stack level above depth");
  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == hrdp_pkg::BK_EMIT && outv_q && !rec_pop_i) |=> $stable(rec_q))
    else $error("record overwritten while waiting");
`endif

endmodule

// ===== src/hid_report_descriptor_parser_core.sv =====
// Top level of the HID report descriptor parser.
//
// Input channel: descriptor bytes with start_req, written like a queue (push/full);
// a byte transfers when push is high and full is low. start_req marks the first
// byte of a new descriptor and clears all parse state.
// Result channel: field records read like a queue (empty/pop); the record on the
// ports transfers when pop is high and empty is low.
// Configuration: cfg_we_i/cfg_wdata_i write field_limit (reset 32), write only
// while idle. It caps the number of records per descriptor (at most FIELD_CAP).
// Completed items are registered in a two-entry queue before the executor takes
// them; a start item first clears the parse state and, when it also completes an
// item, is then executed. An Input item is decoded in the idle state, emits its
// records in the emit state and adds the bits of the count beyond a usage range
// in the finish state. The first record passes through the queue, the idle and
// the emit states into a single output register; records leave at one per cycle
// while the receiver pops. The queue keeps push flowing while the executor is busy
// until it fills. A stalled receiver holds the executor, then the queue, then full.
// Reset clears all parse state; no clearing pass is needed.
module hid_report_descriptor_parser_core #(
  parameter int STACK_DEPTH = 4,
  parameter int USAGE_SLOTS = 8,
  parameter int FIELD_CAP   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  desc_byte_i,
  input  logic        start_req_i,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  field_index_o,
  output logic [7:0]  use_pg_o,
  output logic [15:0] use_code_o,
  output logic [7:0]  rpt_tag_o,
  output logic [15:0] bit_pos_o,
  output logic [7:0]  bit_len_o,
  output logic signed [31:0] lo_limit_o,
  output logic signed [31:0] hi_limit_o,
  output logic        rel_flag_o,
  output logic        last_of_run_o,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);

  logic              accept, item_valid, q_pop, q_valid, rec_valid;
  hrdp_pkg::item_t   item, q_item;
  hrdp_pkg::record_t rec;
  logic [6:0]        field_limit_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_limit_q <= hrdp_pkg::FieldLimitReset;
    end else if (cfg_we_i) begin
      field_limit_q <= cfg_wdata_i;
    end
  end

  assign accept = push && !full;

  hrdp_front u_front (
    .clk_i, .rst_ni,
    .accept_i     (accept),
    .desc_byte_i,
    .start_req_i,
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  hrdp_queue u_queue (
    .clk_i, .rst_ni,
    .wr_i    (item_valid),
    .wdata_i (item),
    .full_o  (full),
    .rd_i    (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_item)
  );

  hrdp_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .USAGE_SLOTS (USAGE_SLOTS),
    .FIELD_CAP   (FIELD_CAP)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .field_limit_i (field_limit_q),
    .rec_valid_o   (rec_valid),
    .rec_o         (rec),
    .rec_pop_i     (pop)
  );

  assign empty         = !rec_valid;
  assign field_index_o = rec.field_index;
  assign use_pg_o      = rec.use_pg;
  assign use_code_o    = rec.use_code;
  assign rpt_tag_o     = rec.rpt_tag;
  assign bit_pos_o     = rec.bit_pos;
  assign bit_len_o     = rec.bit_len;
  assign lo_limit_o    = rec.lo_limit;
  assign hi_limit_o    = rec.hi_limit;
  assign rel_flag_o    = rec.rel_flag;
  assign last_of_run_o = rec.last_of_run;

endmodule
